// ----- rtl/sv32_page_table_mapper_top_macros.svh -----
// assertion macros for the sv32 page table mapper
// used by modules that carry concurrent checks; expects clk and rst_n in scope
`ifndef SV32_PAGE_TABLE_MAPPER_TOP_MACROS_SVH
`define SV32_PAGE_TABLE_MAPPER_TOP_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define SV32PTM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sv32ptm: same-cycle check failed");

// next-cycle implication
`define SV32PTM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sv32ptm: next-cycle check failed");

`endif

// ----- rtl/sv32ptm_pkg.sv -----
// shared types and constants for the sv32 page table mapper
// no dependencies; used by the controller, datapath and top level
package sv32ptm_pkg;

    // sizes
    localparam int TABLE_PAGES_DEF = 8;
    localparam int ENTRIES         = 1024;
    localparam int IDX_W           = 10;
    localparam int SCAN_W          = IDX_W + 1;
    localparam int PPN_W           = 22;
    localparam int VPN_W           = 20;
    localparam int PTE_W           = 32;
    localparam int FLAG_W          = 10;
    localparam int STAT_W          = 3;
    localparam int CFG_IDX_W       = 2;

    // pte flag patterns
    localparam logic [FLAG_W-1:0] PTR_FLAGS  = 10'b0000000001;
    localparam logic [FLAG_W-1:0] LEAF_FLAGS = 10'b0000001111;

    // result codes
    typedef enum logic [STAT_W-1:0] {
        RES_BARE         = 3'd0,
        RES_MAPPED       = 3'd1,
        RES_PROMOTED     = 3'd2,
        RES_ALREADY      = 3'd3,
        RES_NO_SPACE     = 3'd4,
        RES_OUT_OF_STORE = 3'd5
    } status_code_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SV32_ENABLE      = 2'd0,
        CFG_SUPERPAGE_ENABLE = 2'd1,
        CFG_TABLE_BASE_PPN   = 2'd2
    } cfg_index_t;

    // controller states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ROOT_RD,
        S_ROOT_CHK,
        S_LEAF_RD,
        S_LEAF_CHK,
        S_SCAN,
        S_PROMOTE,
        S_RESULT
    } state_t;

    // item payloads
    typedef struct packed {
        logic [VPN_W-1:0] virt_page;
        logic [PPN_W-1:0] phys_page;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              table_allocated;
        logic [PPN_W-1:0]  leaf_table_ppn;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic         clr_step;
        logic         capture;
        logic         rd_root;
        logic         alloc_table;
        logic         use_pointer;
        logic         rd_leaf;
        logic         wr_leaf;
        logic         scan_init;
        logic         scan_step;
        logic         wr_promote;
        logic         set_status;
        status_code_t status_code;
        logic         clear_ppn;
        logic         out_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic sv32_en;
        logic super_en;
        logic root_v;
        logic root_leaf;
        logic root_oos;
        logic no_space;
        logic leaf_v;
        logic scan_miss;
        logic scan_full;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/sv32ptm_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module sv32ptm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read, held while idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/sv32ptm_ctrl.sv -----
// controller state machine for the sv32 page table mapper
// depends on sv32ptm_pkg; drives datapath commands from datapath status
module sv32ptm_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  sv32ptm_pkg::dp_status_t sts,
    output sv32ptm_pkg::ctrl_cmd_t  cmd
);

    sv32ptm_pkg::state_t state_reg;
    sv32ptm_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sv32ptm_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sv32ptm_pkg::S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = sv32ptm_pkg::S_IDLE;
                end
            end
            sv32ptm_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.sv32_en ? sv32ptm_pkg::S_ROOT_RD : sv32ptm_pkg::S_RESULT;
                end
            end
            sv32ptm_pkg::S_ROOT_RD:
            begin
                state_next = sv32ptm_pkg::S_ROOT_CHK;
            end
            sv32ptm_pkg::S_ROOT_CHK:
            begin
                priority if (!sts.root_v)
                begin
                    state_next = sts.no_space ? sv32ptm_pkg::S_RESULT : sv32ptm_pkg::S_LEAF_RD;
                end
                else if (sts.root_leaf || sts.root_oos)
                begin
                    state_next = sv32ptm_pkg::S_RESULT;
                end
                else
                begin
                    state_next = sv32ptm_pkg::S_LEAF_RD;
                end
            end
            sv32ptm_pkg::S_LEAF_RD:
            begin
                state_next = sv32ptm_pkg::S_LEAF_CHK;
            end
            sv32ptm_pkg::S_LEAF_CHK:
            begin
                priority if (sts.leaf_v || !sts.super_en)
                begin
                    state_next = sv32ptm_pkg::S_RESULT;
                end
                else
                begin
                    state_next = sv32ptm_pkg::S_SCAN;
                end
            end
            sv32ptm_pkg::S_SCAN:
            begin
                priority if (sts.scan_miss)
                begin
                    state_next = sv32ptm_pkg::S_RESULT;
                end
                else if (sts.scan_full)
                begin
                    state_next = sv32ptm_pkg::S_PROMOTE;
                end
                else
                begin
                    state_next = sv32ptm_pkg::S_SCAN;
                end
            end
            sv32ptm_pkg::S_PROMOTE:
            begin
                state_next = sv32ptm_pkg::S_RESULT;
            end
            sv32ptm_pkg::S_RESULT:
            begin
                if (sts.out_free)
                begin
                    state_next = sv32ptm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sv32ptm_pkg::S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            sv32ptm_pkg::S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            sv32ptm_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (!sts.sv32_en)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = sv32ptm_pkg::RES_BARE;
                        cmd.clear_ppn   = 1'b1;
                    end
                end
            end
            sv32ptm_pkg::S_ROOT_RD:
            begin
                cmd.rd_root = 1'b1;
            end
            sv32ptm_pkg::S_ROOT_CHK:
            begin
                priority if (!sts.root_v && sts.no_space)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = sv32ptm_pkg::RES_NO_SPACE;
                    cmd.clear_ppn   = 1'b1;
                end
                else if (!sts.root_v)
                begin
                    cmd.alloc_table = 1'b1;
                end
                else if (sts.root_leaf)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = sv32ptm_pkg::RES_ALREADY;
                    cmd.clear_ppn   = 1'b1;
                end
                else if (sts.root_oos)
                begin
                    cmd.use_pointer = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status_code = sv32ptm_pkg::RES_OUT_OF_STORE;
                end
                else
                begin
                    cmd.use_pointer = 1'b1;
                end
            end
            sv32ptm_pkg::S_LEAF_RD:
            begin
                cmd.rd_leaf = 1'b1;
            end
            sv32ptm_pkg::S_LEAF_CHK:
            begin
                priority if (sts.leaf_v)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = sv32ptm_pkg::RES_ALREADY;
                end
                else if (sts.super_en)
                begin
                    cmd.wr_leaf   = 1'b1;
                    cmd.scan_init = 1'b1;
                end
                else
                begin
                    cmd.wr_leaf     = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status_code = sv32ptm_pkg::RES_MAPPED;
                end
            end
            sv32ptm_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_miss)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = sv32ptm_pkg::RES_MAPPED;
                end
            end
            sv32ptm_pkg::S_PROMOTE:
            begin
                cmd.wr_promote  = 1'b1;
                cmd.set_status  = 1'b1;
                cmd.status_code = sv32ptm_pkg::RES_PROMOTED;
            end
            sv32ptm_pkg::S_RESULT:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/sv32ptm_dp.sv -----
// datapath of the sv32 page table mapper: config, pte store, allocator, scan, output
// depends on sv32ptm_pkg, sv32ptm_ram and the assertion macro header
`include "sv32_page_table_mapper_top_macros.svh"

module sv32ptm_dp #(
    parameter int TABLE_PAGES = sv32ptm_pkg::TABLE_PAGES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sv32ptm_pkg::in_item_t               in_data,
    output sv32ptm_pkg::out_item_t              out_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sv32ptm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sv32ptm_pkg::PPN_W-1:0]       cfg_data,
    input  sv32ptm_pkg::ctrl_cmd_t              cmd,
    output sv32ptm_pkg::dp_status_t             sts
);

    localparam int PPN_W   = sv32ptm_pkg::PPN_W;
    localparam int VPN_W   = sv32ptm_pkg::VPN_W;
    localparam int IDX_W   = sv32ptm_pkg::IDX_W;
    localparam int SCAN_W  = sv32ptm_pkg::SCAN_W;
    localparam int PTE_W   = sv32ptm_pkg::PTE_W;
    localparam int FLAG_W  = sv32ptm_pkg::FLAG_W;
    localparam int PW      = $clog2(TABLE_PAGES);
    localparam int NW      = $clog2(TABLE_PAGES + 1);
    localparam int AW      = PW + IDX_W;
    localparam int DEPTH   = TABLE_PAGES * sv32ptm_pkg::ENTRIES;

    // configuration registers
    logic             sv32_en_reg;
    logic             super_en_reg;
    logic [PPN_W-1:0] base_reg;

    // request context
    logic [VPN_W-1:0]          vpn_reg;
    logic [PPN_W-1:0]          ppn_in_reg;
    logic [PW-1:0]             page_reg;
    logic [PPN_W-1:0]          tppn_reg;
    logic                      alloc_reg;
    sv32ptm_pkg::status_code_t res_status_reg;
    logic [PTE_W-1:0]          leaf0_reg;

    // control counters
    logic [NW-1:0]     nft_reg;
    logic [NW-1:0]     nft_next;
    logic [AW-1:0]     clr_cnt_reg;
    logic [AW-1:0]     clr_cnt_next;
    logic [SCAN_W-1:0] scan_cnt_reg;
    logic [SCAN_W-1:0] scan_cnt_next;
    logic              scan_pend_reg;
    logic              scan_pend_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    sv32ptm_pkg::out_item_t out_data_reg;

    // ram port signals
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [PTE_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [PTE_W-1:0] ram_rdata;

    // derived values
    logic [AW-1:0]    root_addr;
    logic [AW-1:0]    leaf_addr;
    logic [AW-1:0]    scan_addr;
    logic [PPN_W-1:0] root_ppn;
    logic [PPN_W-1:0] ptr_page;
    logic [PPN_W-1:0] new_ppn;
    logic             scan_issue;
    logic             out_free;

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv32_en_reg  <= 1'b0;
            super_en_reg <= 1'b0;
            base_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sv32ptm_pkg::CFG_SV32_ENABLE:      sv32_en_reg  <= cfg_data[0];
                sv32ptm_pkg::CFG_SUPERPAGE_ENABLE: super_en_reg <= cfg_data[0];
                sv32ptm_pkg::CFG_TABLE_BASE_PPN:   base_reg     <= cfg_data;
                default:                           base_reg     <= base_reg;
            endcase
        end
    end

    // addresses and root pointer arithmetic
    assign root_addr  = {{PW{1'b0}}, vpn_reg[VPN_W-1:IDX_W]};
    assign leaf_addr  = {page_reg, vpn_reg[IDX_W-1:0]};
    assign scan_addr  = {page_reg, scan_cnt_reg[IDX_W-1:0]};
    assign root_ppn   = ram_rdata[PTE_W-1:FLAG_W];
    assign ptr_page   = root_ppn - base_reg;
    assign new_ppn    = base_reg + PPN_W'(nft_reg[PW-1:0]);
    assign scan_issue = cmd.scan_step && !scan_cnt_reg[IDX_W];
    assign out_free   = !out_valid_reg || out_ready;

    // status back to the controller
    always_comb
    begin
        sts            = '0;
        sts.clear_last = (clr_cnt_reg == AW'(DEPTH - 1));
        sts.sv32_en    = sv32_en_reg;
        sts.super_en   = super_en_reg;
        sts.root_v     = ram_rdata[0];
        sts.root_leaf  = |ram_rdata[3:1];
        sts.root_oos   = (ptr_page >= PPN_W'(TABLE_PAGES));
        sts.no_space   = (nft_reg >= NW'(TABLE_PAGES));
        sts.leaf_v     = ram_rdata[0];
        sts.scan_miss  = scan_pend_reg && !ram_rdata[0];
        sts.scan_full  = scan_pend_reg && ram_rdata[0] && scan_cnt_reg[IDX_W];
        sts.out_free   = out_free;
    end

    // store write port select
    always_comb
    begin
        ram_we    = cmd.clr_step || cmd.alloc_table || cmd.wr_leaf || cmd.wr_promote;
        ram_waddr = clr_cnt_reg;
        ram_wdata = '0;
        priority if (cmd.alloc_table)
        begin
            ram_waddr = root_addr;
            ram_wdata = {new_ppn, sv32ptm_pkg::PTR_FLAGS};
        end
        else if (cmd.wr_leaf)
        begin
            ram_waddr = leaf_addr;
            ram_wdata = {ppn_in_reg, sv32ptm_pkg::LEAF_FLAGS};
        end
        else if (cmd.wr_promote)
        begin
            ram_waddr = root_addr;
            ram_wdata = leaf0_reg;
        end
        else
        begin
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
    end

    // store read port select
    always_comb
    begin
        ram_re = cmd.rd_root || cmd.rd_leaf || scan_issue;
        priority if (cmd.rd_root)
        begin
            ram_raddr = root_addr;
        end
        else if (cmd.rd_leaf)
        begin
            ram_raddr = leaf_addr;
        end
        else
        begin
            ram_raddr = scan_addr;
        end
    end

    sv32ptm_ram #(
        .WIDTH (PTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next values of control counters
    always_comb
    begin
        nft_next       = nft_reg;
        clr_cnt_next   = clr_cnt_reg;
        scan_cnt_next  = scan_cnt_reg;
        scan_pend_next = scan_pend_reg;
        out_valid_next = out_valid_reg;
        if (cmd.alloc_table)
        begin
            nft_next = nft_reg + NW'(1);
        end
        if (cmd.clr_step)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
        end
        priority if (cmd.scan_init)
        begin
            scan_cnt_next  = '0;
            scan_pend_next = 1'b0;
        end
        else if (cmd.scan_step)
        begin
            scan_pend_next = scan_issue;
            if (scan_issue)
            begin
                scan_cnt_next = scan_cnt_reg + SCAN_W'(1);
            end
        end
        else
        begin
            scan_pend_next = scan_pend_reg;
        end
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nft_reg       <= NW'(1);
            clr_cnt_reg   <= '0;
            scan_cnt_reg  <= '0;
            scan_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            nft_reg       <= nft_next;
            clr_cnt_reg   <= clr_cnt_next;
            scan_cnt_reg  <= scan_cnt_next;
            scan_pend_reg <= scan_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request context and result fields
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            vpn_reg    <= in_data.virt_page;
            ppn_in_reg <= in_data.phys_page;
        end
        priority if (cmd.clear_ppn || cmd.capture)
        begin
            alloc_reg <= 1'b0;
        end
        else if (cmd.alloc_table)
        begin
            alloc_reg <= 1'b1;
        end
        else
        begin
            alloc_reg <= alloc_reg;
        end
        priority if (cmd.clear_ppn)
        begin
            tppn_reg <= '0;
        end
        else if (cmd.alloc_table)
        begin
            tppn_reg <= new_ppn;
            page_reg <= nft_reg[PW-1:0];
        end
        else if (cmd.use_pointer)
        begin
            tppn_reg <= root_ppn;
            page_reg <= ptr_page[PW-1:0];
        end
        else
        begin
            tppn_reg <= tppn_reg;
        end
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status_code;
        end
        // leaf 0 comes back while the scan counter reads one
        if (scan_pend_reg && (scan_cnt_reg == SCAN_W'(1)))
        begin
            leaf0_reg <= ram_rdata;
        end
        if (cmd.out_load)
        begin
            out_data_reg.status          <= res_status_reg;
            out_data_reg.table_allocated <= alloc_reg;
            out_data_reg.leaf_table_ppn  <= tppn_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    `SV32PTM_ASSERT_IMP(a_no_rw_collision, ram_we && ram_re, ram_waddr != ram_raddr)
    `SV32PTM_ASSERT_IMP(a_free_page_range, 1'b1, (nft_reg != '0) && (nft_reg <= NW'(TABLE_PAGES)))
    `SV32PTM_ASSERT_IMP(a_load_only_when_free, cmd.out_load, !out_valid_reg || out_ready)
    `SV32PTM_ASSERT_NEXT(a_alloc_bumps_page, cmd.alloc_table, nft_reg == $past(nft_reg) + NW'(1))
    `SV32PTM_ASSERT_IMP(a_promote_from_valid_leaf, cmd.wr_promote, leaf0_reg[0])

endmodule

// ----- rtl/sv32_page_table_mapper_top.sv -----
// top level of the sv32 page table mapper
// depends on sv32ptm_pkg, sv32ptm_ctrl and sv32ptm_dp
//
// Each input item inserts one Sv32 mapping into a two-level table held in an
// internal store of TABLE_PAGES pages of 1024 PTEs, page 0 being the root, and
// returns one result item. After reset a clearing pass zeroes the store, one
// entry per cycle, with in_ready low; config writes are taken at any time. The
// store has one read and one write port, and the controller walks root read,
// root check, leaf read and leaf check one step a cycle: a bare-mode item skips
// the walk and goes straight to the result state, and a lookup may end at the
// root check. With superpaging on, the leaf table is scanned one store read per
// cycle, stopping at the first invalid leaf. A held output register delays the
// load until it drains. The next item is taken the cycle after the result is
// loaded, while that result still waits in the output register.
module sv32_page_table_mapper_top #(
    parameter int TABLE_PAGES = sv32ptm_pkg::TABLE_PAGES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  sv32ptm_pkg::in_item_t             in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output sv32ptm_pkg::out_item_t            out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sv32ptm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sv32ptm_pkg::PPN_W-1:0]     cfg_data
);

    sv32ptm_pkg::ctrl_cmd_t  cmd;
    sv32ptm_pkg::dp_status_t sts;

    // sequencer
    sv32ptm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // store, allocator and result path
    sv32ptm_dp #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ----- tb/sv/sv32ptm_checker.sv -----
// scoreboard for the sv32 page table mapper: watches the config, input and result channels
// keeps its own copy of the pte store and predicts every result; depends on sv32ptm_pkg
module sv32ptm_checker
    import sv32ptm_pkg::*;
#(
    parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  in_item_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  out_item_t            out_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PPN_W-1:0]     cfg_data,
    output int                   mismatches,
    output int                   results_owed
);

    localparam int STORE_DEPTH = TABLE_PAGES * ENTRIES;

    // shadow of the block state
    logic [PTE_W-1:0] pte_shadow [STORE_DEPTH];
    int unsigned      next_table;
    logic             sv32_on;
    logic             super_on;
    logic [PPN_W-1:0] base_ppn;

    out_item_t expected_q [$];
    int        bad_count;

    // insert one mapping into the shadow tables and return the result it should give
    function automatic out_item_t predict_insert(input in_item_t item);
        logic [IDX_W-1:0] hi;
        logic [IDX_W-1:0] lo;
        logic [PTE_W-1:0] root;
        logic [PPN_W-1:0] tppn;
        logic [PPN_W-1:0] page_off;
        int unsigned      page;
        int unsigned      first;
        bit               full;
        out_item_t        r;
        r = '0;
        if (!sv32_on)
        begin
            r.status = RES_BARE;
            return r;
        end
        hi   = item.virt_page[VPN_W-1:IDX_W];
        lo   = item.virt_page[IDX_W-1:0];
        root = pte_shadow[hi];
        if (!root[0])
        begin
            // invalid root: take the next free page as a leaf table
            if (next_table >= TABLE_PAGES)
            begin
                r.status = RES_NO_SPACE;
                return r;
            end
            page       = next_table;
            next_table = next_table + 1;
            tppn       = base_ppn + PPN_W'(page);
            pte_shadow[hi] = {tppn, PTR_FLAGS};
            r.table_allocated = 1'b1;
        end
        else if (root[3:1] != 3'b000)
        begin
            // root is already a leaf, e.g. after promotion
            r.status = RES_ALREADY;
            return r;
        end
        else
        begin
            tppn     = root[PTE_W-1:FLAG_W];
            page_off = tppn - base_ppn;
            if (page_off >= TABLE_PAGES)
            begin
                r.status         = RES_OUT_OF_STORE;
                r.leaf_table_ppn = tppn;
                return r;
            end
            page = page_off;
        end
        r.leaf_table_ppn = tppn;
        first = page * ENTRIES;
        if (pte_shadow[first + lo][0])
        begin
            r.status = RES_ALREADY;
            return r;
        end
        pte_shadow[first + lo] = {item.phys_page, LEAF_FLAGS};
        // promote a fully valid leaf table
        if (super_on)
        begin
            full = 1'b1;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (!pte_shadow[first + i][0])
                begin
                    full = 1'b0;
                    break;
                end
            end
            if (full)
            begin
                pte_shadow[hi] = pte_shadow[first];
                r.status = RES_PROMOTED;
                return r;
            end
        end
        r.status = RES_MAPPED;
        return r;
    endfunction

    // follow the channels at every edge
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
                pte_shadow[i] = '0;
            next_table = 1;
            sv32_on    = 1'b0;
            super_on   = 1'b0;
            base_ppn   = '0;
            expected_q.delete();
            bad_count  = 0;
            mismatches   <= 0;
            results_owed <= 0;
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_SV32_ENABLE:      sv32_on  = cfg_data[0];
                    CFG_SUPERPAGE_ENABLE: super_on = cfg_data[0];
                    CFG_TABLE_BASE_PPN:   base_ppn = cfg_data;
                    default: ;
                endcase
            end
            // accepted item
            if (in_valid && in_ready)
                expected_q = {expected_q, predict_insert(in_data)};
            // accepted result against the oldest expectation
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("result with no item pending: status %0d alloc %0d ppn %h",
                                 out_data.status, out_data.table_allocated,
                                 out_data.leaf_table_ppn);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_data.status !== want.status
                        || out_data.table_allocated !== want.table_allocated
                        || out_data.leaf_table_ppn !== want.leaf_table_ppn)
                    begin
                        bad_count++;
                        if (bad_count <= 10)
                            $display("mismatch: expected status %0d alloc %0d ppn %h, got %0d %0d %h",
                                     want.status, want.table_allocated, want.leaf_table_ppn,
                                     out_data.status, out_data.table_allocated,
                                     out_data.leaf_table_ppn);
                    end
                end
            end
            mismatches   <= bad_count;
            results_owed <= expected_q.size();
        end
    end

endmodule

// ----- tb/sv/tb_sv32_page_table_mapper_top.sv -----
// testbench top for the sv32 page table mapper: clock, reset, stimulus and verdict
// depends on sv32ptm_pkg, sv32_page_table_mapper_top and sv32ptm_checker
module tb_sv32_page_table_mapper_top;
    import sv32ptm_pkg::*;

    localparam int STALL_LIMIT = 50000;
    localparam int HOLD_OFF    = 400;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PPN_W-1:0]     cfg_data;
    int                   mismatches;
    int                   results_owed;
    int                   burst_left;
    int                   idle_cycles;
    logic [VPN_W-1:0]     sent_pages [$];

    sv32_page_table_mapper_top #(
        .TABLE_PAGES(TABLE_PAGES_DEF)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sv32ptm_checker #(
        .TABLE_PAGES(TABLE_PAGES_DEF)
    ) scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb_sv32_page_table_mapper_top: FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: stall patterns plus one long hold-off
    initial
    begin
        int taken;
        int span;
        int mode;
        bit held;
        taken = 0;
        held  = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            span = $urandom_range(20, 200);
            mode = $urandom_range(0, 2);
            repeat (span)
            begin
                if (!held && taken >= 40)
                begin
                    held = 1'b1;
                    out_ready <= 1'b0;
                    repeat (HOLD_OFF) @(posedge clk);
                end
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge clk);
                if (out_valid && out_ready)
                    taken++;
            end
        end
    end

    // offer one item, usually opening a gap when a burst runs out
    task automatic offer_item(input logic [VPN_W-1:0] vp, input logic [PPN_W-1:0] pp);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_data  <= {vp, pp};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
        sent_pages = {sent_pages, vp};
    endtask

    // stop sending until every result is back and the block has settled
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (12) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [PPN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // program all three registers while the block is idle
    task automatic set_mode(input bit sv, input bit sp, input logic [PPN_W-1:0] base);
        wait_for_results();
        write_reg(CFG_SV32_ENABLE, PPN_W'(sv));
        write_reg(CFG_SUPERPAGE_ENABLE, PPN_W'(sp));
        write_reg(CFG_TABLE_BASE_PPN, base);
        cfg_valid <= 1'b0;
    endtask

    // roots that already hold tables after the directed part
    function automatic logic [IDX_W-1:0] known_root();
        case ($urandom_range(0, 3))
            0:       return 10'h000;
            1:       return 10'h3ff;
            2:       return 10'h155;
            default: return 10'h2aa;
        endcase
    endfunction

    // map leaves zero up to count-1 of one table in shuffled order
    task automatic fill_table(input logic [IDX_W-1:0] hi, input int count);
        int order [ENTRIES];
        int j;
        int t;
        for (int i = 0; i < count; i++)
            order[i] = i;
        for (int i = count - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < count; i++)
            offer_item({hi, IDX_W'(order[i])}, PPN_W'($urandom));
    endtask

    // random inserts: known roots, fresh roots and repeats of earlier pages
    task automatic run_mix(input int count);
        int               pick;
        logic [IDX_W-1:0] hi;
        logic [VPN_W-1:0] vp;
        logic [PPN_W-1:0] pp;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15 && sent_pages.size() > 0)
                vp = sent_pages[$urandom_range(0, sent_pages.size() - 1)];
            else
            begin
                hi = (pick < 30) ? IDX_W'($urandom) : known_root();
                vp = {hi, IDX_W'($urandom)};
            end
            case ($urandom_range(0, 9))
                0:       pp = '0;
                1:       pp = '1;
                default: pp = PPN_W'($urandom);
            endcase
            offer_item(vp, pp);
            if ($urandom_range(0, 59) == 0)
                wait_for_results();
        end
    endtask

    // stimulus and verdict
    initial
    begin
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SV32_ENABLE;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        burst_left = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bare mode straight out of reset
        offer_item(20'h00000, 22'h000000);
        offer_item(20'hfffff, 22'h3fffff);
        offer_item(20'h55555, 22'h2aaaaa);

        // base near the top so table ppns wrap
        set_mode(1'b1, 1'b0, 22'h3ffffd);
        offer_item(20'h00000, 22'h000000);
        offer_item(20'h00000, 22'h123456);
        offer_item(20'h003ff, 22'h3fffff);
        offer_item(20'hfffff, 22'h3fffff);
        offer_item(20'hffc00, 22'h000001);
        offer_item(20'h55555, 22'h2aaaaa);
        offer_item(20'h55555, 22'h155555);
        offer_item(20'h554aa, 22'h000abc);

        // moved base: existing pointers fall outside the store
        set_mode(1'b1, 1'b0, 22'h000100);
        offer_item(20'h00001, 22'h000001);
        offer_item(20'hffc01, 22'h3ffffe);
        offer_item(20'h55400, 22'h200000);

        // superpaging on a sparse table
        set_mode(1'b1, 1'b1, 22'h3ffffd);
        offer_item(20'h00002, 22'h000003);

        // map a long run of leaves from zero so scans walk far, then revisit the table
        fill_table(10'h2aa, 300);
        offer_item(20'haa923, 22'h0f0f0f);
        offer_item(20'haa800, 22'h3f0f0f);

        // random phases across settings
        set_mode(1'b1, 1'b0, 22'h3ffffd);
        run_mix(50);
        set_mode(1'b1, 1'b1, 22'h3ffffd);
        run_mix(40);
        set_mode(1'b0, 1'b1, 22'h3ffffd);
        run_mix(30);
        set_mode(1'b1, 1'b0, 22'h3fffff);
        run_mix(40);
        set_mode(1'b1, 1'b1, 22'h000000);
        run_mix(40);
        set_mode(1'b1, 1'b0, 22'h3ffffd);
        run_mix(30);

        wait_for_results();
        if (mismatches == 0)
            $display("tb_sv32_page_table_mapper_top: PASS");
        else
            $display("tb_sv32_page_table_mapper_top: FAIL");
        $finish;
    end

endmodule
